// ===== rtl/hidrb_pkg.sv =====
package hidrb_pkg;

    // Report geometry
    localparam int SLOT_FIELDS   = 6;
    localparam int KEY_SLOTS_DEF = 6;
    localparam int CODE_W        = 8;

    // Modifier usages occupy 0xE0..0xE7: upper five bits fixed, low three pick the bit
    localparam logic [4:0]        MOD_PREFIX = 5'b11100;
    localparam logic [CODE_W-1:0] SENT_RESET = 8'hFF;
    localparam logic [CODE_W-1:0] SLOT_EMPTY = 8'h00;

    typedef enum logic [0:0] {
        KIND_REPORT = 1'b0,
        KIND_WAKE   = 1'b1
    } result_kind_t;

    // Per-word control broadcast to every slot cell
    typedef struct packed {
        logic take_key;    // accepted word carries a pressed non-modifier key
        logic close_scan;  // accepted word ends the scan
        logic commit;      // report goes out, so latch it as sent
    } cell_ctl_t;

endpackage

// ===== rtl/key_matrix_hid_report_builder.sv =====
// Boot-protocol HID report builder for a scanned key matrix.
// Key channel (key_valid / key_stall): one word per matrix position in scan
// order, carrying key_pressed, the mapped key_code and end_of_scan; the host
// flags are looked at only on the end-of-scan word.
// Report channel (report_valid / report_stall): at most one word per scan,
// either a report (modifier_bits and six slots) or a wake-up request.
// Throughput: one key word per clock while key_stall is low, through a row of slot
// cells that fill left to right and pass a difference flag along the row.
// Latency: the result of an end-of-scan word appears on the report port in
// the cycle after that word is accepted, from a single output register.
// When the receiver stalls a pending result, key_stall rises and holds the
// key channel until the result is taken; key words are otherwise taken
// while an earlier result waits.
// Reset clears the scan in progress and sets the last-sent report to all
// 0xFF, so the first finished scan produces a result if the host is suspended or ready, unless it is all 0xFF itself.
module key_matrix_hid_report_builder #(
    parameter int KEY_SLOTS = hidrb_pkg::KEY_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         key_valid,
    output logic                         key_stall,
    input  logic                         key_pressed,
    input  logic [hidrb_pkg::CODE_W-1:0] key_code,
    input  logic                         end_of_scan,
    input  logic                         host_suspended,
    input  logic                         host_ready,
    output logic                         report_valid,
    input  logic                         report_stall,
    output logic                         result_kind,
    output logic [hidrb_pkg::CODE_W-1:0] modifier_bits,
    output logic [hidrb_pkg::CODE_W-1:0] slot_0,
    output logic [hidrb_pkg::CODE_W-1:0] slot_1,
    output logic [hidrb_pkg::CODE_W-1:0] slot_2,
    output logic [hidrb_pkg::CODE_W-1:0] slot_3,
    output logic [hidrb_pkg::CODE_W-1:0] slot_4,
    output logic [hidrb_pkg::CODE_W-1:0] slot_5
);
    import hidrb_pkg::*;

    logic              accept;
    logic              is_mod;
    logic [CODE_W-1:0] mod_set;
    logic [CODE_W-1:0] mod_now;
    logic              changed;
    logic              send_wake;
    logic              send_report;
    cell_ctl_t         ctl;

    logic              filled_chain [SLOT_FIELDS+1];
    logic              diff_chain   [SLOT_FIELDS+1];
    logic [CODE_W-1:0] slot_now     [SLOT_FIELDS];

    logic [CODE_W-1:0] scan_mod_reg;
    logic [CODE_W-1:0] scan_mod_next;
    logic [CODE_W-1:0] sent_mod_reg;
    logic [CODE_W-1:0] sent_mod_next;

    logic              report_valid_reg;
    logic              report_valid_next;
    result_kind_t      kind_reg;
    logic [CODE_W-1:0] mod_out_reg;
    logic [CODE_W-1:0] slot_out_reg [SLOT_FIELDS];

    // Hold the key channel only while a finished result is stalled
    assign key_stall = report_valid_reg && report_stall;
    assign accept    = key_valid && !key_stall;

    // Decode modifier usages
    assign is_mod  = (key_code[CODE_W-1:3] == MOD_PREFIX);
    assign mod_set = (key_pressed && is_mod) ? (CODE_W'(1) << key_code[2:0]) : '0;
    assign mod_now = scan_mod_reg | mod_set;

    // Broadcast per-word control to the cell row
    assign ctl.take_key   = accept && key_pressed && !is_mod;
    assign ctl.close_scan = accept && end_of_scan;
    assign ctl.commit     = send_report;

    // Row of slot cells: fill flag and difference flag ripple left to right
    assign filled_chain[0] = 1'b1;
    assign diff_chain[0]   = (mod_now != sent_mod_reg);

    for (genvar i = 0; i < SLOT_FIELDS; i++)
    begin : g_cell
        hidrb_slot_cell #(
            .FILLABLE (i < KEY_SLOTS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .code        (key_code),
            .prev_filled (filled_chain[i]),
            .filled      (filled_chain[i+1]),
            .diff_in     (diff_chain[i]),
            .diff_out    (diff_chain[i+1]),
            .slot_now    (slot_now[i])
        );
    end

    // Decide what the end-of-scan word produces
    assign changed     = diff_chain[SLOT_FIELDS];
    assign send_wake   = ctl.close_scan && changed && host_suspended;
    assign send_report = ctl.close_scan && changed && !host_suspended && host_ready;

    // Advance modifier accumulator and last-sent modifiers
    always_comb
    begin
        scan_mod_next = scan_mod_reg;
        sent_mod_next = sent_mod_reg;
        if (ctl.close_scan)
        begin
            scan_mod_next = '0;
            if (send_report)
            begin
                sent_mod_next = mod_now;
            end
        end
        else if (accept)
        begin
            scan_mod_next = mod_now;
        end
    end

    // Output word is valid until taken, reloaded on a new result
    assign report_valid_next = send_wake || send_report ||
                               (report_valid_reg && report_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_mod_reg     <= '0;
            sent_mod_reg     <= SENT_RESET;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            scan_mod_reg     <= scan_mod_next;
            sent_mod_reg     <= sent_mod_next;
            report_valid_reg <= report_valid_next;
        end
    end

    // Load the output word payload
    always_ff @(posedge clk)
    begin
        if (send_wake)
        begin
            kind_reg    <= KIND_WAKE;
            mod_out_reg <= '0;
            for (int k = 0; k < SLOT_FIELDS; k++)
            begin
                slot_out_reg[k] <= SLOT_EMPTY;
            end
        end
        else if (send_report)
        begin
            kind_reg    <= KIND_REPORT;
            mod_out_reg <= mod_now;
            for (int k = 0; k < SLOT_FIELDS; k++)
            begin
                slot_out_reg[k] <= slot_now[k];
            end
        end
    end

    assign report_valid  = report_valid_reg;
    assign result_kind   = kind_reg;
    assign modifier_bits = mod_out_reg;
    assign slot_0        = slot_out_reg[0];
    assign slot_1        = slot_out_reg[1];
    assign slot_2        = slot_out_reg[2];
    assign slot_3        = slot_out_reg[3];
    assign slot_4        = slot_out_reg[4];
    assign slot_5        = slot_out_reg[5];

endmodule

// ===== rtl/hidrb_slot_cell.sv =====
module hidrb_slot_cell #(
    parameter bit FILLABLE = 1'b1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hidrb_pkg::cell_ctl_t        ctl,
    input  logic [hidrb_pkg::CODE_W-1:0] code,
    input  logic                        prev_filled,
    output logic                        filled,
    input  logic                        diff_in,
    output logic                        diff_out,
    output logic [hidrb_pkg::CODE_W-1:0] slot_now
);
    import hidrb_pkg::*;

    logic              filled_reg;
    logic              filled_next;
    logic [CODE_W-1:0] scan_reg;
    logic [CODE_W-1:0] scan_next;
    logic [CODE_W-1:0] sent_reg;
    logic [CODE_W-1:0] sent_next;
    logic              take_here;

    // This cell is the next free slot when its left neighbor already holds a key
    assign take_here = FILLABLE && ctl.take_key && prev_filled && !filled_reg;

    // Slot contents including the word being accepted now
    assign slot_now = take_here ? code : scan_reg;

    // Hand the fill state and the running difference to the right neighbor
    assign filled   = filled_reg;
    assign diff_out = diff_in || (slot_now != sent_reg);

    always_comb
    begin
        filled_next = filled_reg;
        scan_next   = scan_reg;
        sent_next   = sent_reg;
        if (ctl.close_scan)
        begin
            filled_next = 1'b0;
            scan_next   = SLOT_EMPTY;
            if (ctl.commit)
            begin
                sent_next = slot_now;
            end
        end
        else if (take_here)
        begin
            filled_next = 1'b1;
            scan_next   = code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            scan_reg   <= SLOT_EMPTY;
            sent_reg   <= SENT_RESET;
        end
        else
        begin
            filled_reg <= filled_next;
            scan_reg   <= scan_next;
            sent_reg   <= sent_next;
        end
    end

endmodule
